[sv/dmgrc_pkg.sv]
package dmgrc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROW,
        ST_SCAN,
        ST_APPLY,
        ST_ACC,
        ST_CHECK,
        ST_DONE
    } t_state;

    localparam logic [1:0] OP_LOAD_FAC  = 2'd0;
    localparam logic [1:0] OP_LOAD_COST = 2'd1;
    localparam logic [1:0] OP_LOAD_FLOW = 2'd2;
    localparam logic [1:0] OP_COMPUTE   = 2'd3;

    localparam int DELTA_W = 38;
    localparam int SUM_W   = 48;
    localparam int RC_W    = 17;
    localparam int PROD_W  = 34;

    localparam logic signed [SUM_W-1:0] SUM_DMAX = 48'sd137438953471;
    localparam logic signed [SUM_W-1:0] SUM_DMIN = -48'sd137438953472;

endpackage

[sv/drop_move_greedy_reassign_cost.sv]
// Greedy drop-move cost estimator. Loads (facility, cost, flow) are written
// while idle. A compute reads the dropped facility's cost row, then repeats a
// selection round: one pass over the cost memory, one read per cycle through
// its registered read port, finds the cheapest arc whose facility still has
// slack and whose client still has demand, then moves min(slack, demand)
// units in the apply and accumulate states. Each round empties a receiving
// facility or a client, so there are at most FACILITIES + CLIENTS - 1 moves and
// one last pass that finds nothing. The cost memory has a single read port.
// With an out-of-range facility, no receiving slack or no flow, a compute
// skips the rounds and gives a zero delta. Leftover demand gives infeasible = 1
// with the largest positive delta.
module drop_move_greedy_reassign_cost
    import dmgrc_pkg::*;
#(
    parameter int FACILITIES = 16,
    parameter int CLIENTS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_operation,
    input  logic [3:0]                i_facility,
    input  logic [3:0]                i_client,
    input  logic [15:0]               i_amount,
    input  logic                      i_open_flag,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DELTA_W-1:0] o_delta_cost,
    output logic                      o_infeasible
);

    localparam int FW    = $clog2(FACILITIES);
    localparam int CW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int DEPTH = FACILITIES * CLIENTS;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [15:0] r_spare [FACILITIES];
    logic        r_open  [FACILITIES];
    logic [15:0] r_flow  [CLIENTS];
    logic [15:0] r_slack [FACILITIES];
    logic [15:0] r_dem   [CLIENTS];
    logic [15:0] r_dcost [CLIENTS];

    logic [FW-1:0] r_f, r_pf, r_mf;
    logic [CW-1:0] r_c, r_pc, r_mc;
    logic [AW-1:0] r_addr;
    logic          r_issue, r_rv, r_found, r_left;
    logic signed [RC_W-1:0]   r_min;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_oval;
    logic signed [DELTA_W-1:0] r_odelta;
    logic                      r_oinf;

    logic [6:0]    fac_x, cli_x;
    logic          fac_ok, cli_ok, in_acc;
    logic [FW-1:0] fac_i;
    logic [CW-1:0] cli_i;
    logic [15:0]   slack_init [FACILITIES];
    logic          any_slack, any_flow, any_dem;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_rdata;
    logic signed [RC_W-1:0] cap_rc;
    logic          cap_live, issue_last, drow_last;
    logic [15:0]   mv;
    logic signed [SUM_W-1:0] clamp_sum;

    assign fac_x  = 7'(i_facility);
    assign cli_x  = 7'(i_client);
    assign fac_ok = fac_x < 7'(FACILITIES);
    assign cli_ok = cli_x < 7'(CLIENTS);
    assign fac_i  = fac_x[FW-1:0];
    assign cli_i  = cli_x[CW-1:0];
    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        any_slack = 1'b0;
        for (int f = 0; f < FACILITIES; f++) begin
            slack_init[f] = (FW'(f) != fac_i && r_open[f]) ? r_spare[f] : 16'd0;
            any_slack     = any_slack | (slack_init[f] != 16'd0);
        end
        any_flow = 1'b0;
        any_dem  = 1'b0;
        for (int c = 0; c < CLIENTS; c++) begin
            any_flow = any_flow | (r_flow[c] != 16'd0);
            any_dem  = any_dem | (r_dem[c] != 16'd0);
        end
    end

    assign ram_we    = in_acc && i_operation == OP_LOAD_COST && fac_ok && cli_ok;
    assign ram_waddr = AW'(fac_i) * AW'(CLIENTS) + AW'(cli_i);

    dmgrc_ram #(.DEPTH(DEPTH), .WIDTH(16)) u_cost (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_amount),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cap_rc     = $signed({1'b0, ram_rdata}) - $signed({1'b0, r_dcost[r_pc]});
    assign cap_live   = r_slack[r_pf] != 16'd0 && r_dem[r_pc] != 16'd0;
    assign issue_last = r_f == FW'(FACILITIES - 1) && r_c == CW'(CLIENTS - 1);
    assign drow_last  = r_c == CW'(CLIENTS - 1);
    assign mv = (r_slack[r_mf] < r_dem[r_mc]) ? r_slack[r_mf] : r_dem[r_mc];
    assign clamp_sum = (r_sum > SUM_DMAX) ? SUM_DMAX :
                       (r_sum < SUM_DMIN) ? SUM_DMIN : r_sum;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_operation == OP_COMPUTE) begin
                    n_state = (fac_ok && any_slack && any_flow) ? ST_DROW : ST_DONE;
                end
            end
            ST_DROW:  if (!r_issue && !r_rv) n_state = ST_SCAN;
            ST_SCAN:  if (!r_issue && !r_rv) n_state = ST_APPLY;
            ST_APPLY: n_state = r_found ? ST_ACC : ST_CHECK;
            ST_ACC:   n_state = ST_SCAN;
            ST_CHECK: n_state = ST_DONE;
            ST_DONE:  if (!r_oval || i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        ram_raddr  = r_addr;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
            r_issue <= 1'b0;
            r_rv    <= 1'b0;
            for (int f = 0; f < FACILITIES; f++) begin
                r_open[f]  <= 1'b0;
                r_spare[f] <= 16'd0;
            end
            for (int c = 0; c < CLIENTS; c++) begin
                r_flow[c] <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            r_oval  <= (r_oval && !i_out_ready) ||
                       (r_state == ST_DONE && (!r_oval || i_out_ready));
            // read data is valid in the cycle after an issued address
            r_rv    <= r_issue && (r_state == ST_DROW || r_state == ST_SCAN);
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_operation)
                            OP_LOAD_FAC: begin
                                if (fac_ok) begin
                                    r_open[fac_i]  <= i_open_flag;
                                    r_spare[fac_i] <= i_amount;
                                end
                            end
                            OP_LOAD_FLOW: begin
                                if (cli_ok) begin
                                    r_flow[cli_i] <= i_amount;
                                end
                            end
                            OP_COMPUTE: begin
                                r_sum   <= '0;
                                r_left  <= 1'b0;
                                r_addr  <= AW'(fac_i) * AW'(CLIENTS);
                                r_c     <= '0;
                                r_issue <= 1'b1;
                                for (int f = 0; f < FACILITIES; f++) begin
                                    r_slack[f] <= slack_init[f];
                                end
                                for (int c = 0; c < CLIENTS; c++) begin
                                    r_dem[c] <= r_flow[c];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DROW: begin
                    if (r_issue) begin
                        r_pc   <= r_c;
                        r_c    <= r_c + 1'b1;
                        r_addr <= r_addr + 1'b1;
                        if (drow_last) r_issue <= 1'b0;
                    end
                    if (r_rv) begin
                        r_dcost[r_pc] <= ram_rdata;
                    end
                    if (!r_issue && !r_rv) begin
                        r_f     <= '0;
                        r_c     <= '0;
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                        r_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (r_issue) begin
                        r_pf   <= r_f;
                        r_pc   <= r_c;
                        r_addr <= r_addr + 1'b1;
                        if (r_c == CW'(CLIENTS - 1)) begin
                            r_c <= '0;
                            r_f <= r_f + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                        if (issue_last) r_issue <= 1'b0;
                    end
                    // strict compare keeps the lowest facility, then client, on ties
                    if (r_rv && cap_live && (!r_found || cap_rc < r_min)) begin
                        r_found <= 1'b1;
                        r_min   <= cap_rc;
                        r_mf    <= r_pf;
                        r_mc    <= r_pc;
                    end
                end
                ST_APPLY: begin
                    if (r_found) begin
                        r_prod       <= PROD_W'(r_min * $signed({1'b0, mv}));
                        r_slack[r_mf] <= r_slack[r_mf] - mv;
                        r_dem[r_mc]   <= r_dem[r_mc] - mv;
                    end
                end
                ST_ACC: begin
                    r_sum   <= r_sum + SUM_W'(r_prod);
                    r_f     <= '0;
                    r_c     <= '0;
                    r_addr  <= '0;
                    r_issue <= 1'b1;
                    r_found <= 1'b0;
                end
                ST_CHECK: begin
                    r_left <= any_dem;
                end
                ST_DONE: begin
                    if (!r_oval || i_out_ready) begin
                        r_oinf   <= r_left;
                        r_odelta <= r_left ? DELTA_W'(SUM_DMAX) : DELTA_W'(clamp_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_oval;
    assign o_delta_cost = r_odelta;
    assign o_infeasible = r_oinf;

endmodule

[sv/dmgrc_ram.sv]
module dmgrc_ram
    import dmgrc_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[tb/tb.sv]
module tb;
    import dmgrc_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  fac;
        logic [3:0]  cli;
        logic [15:0] amt;
        logic        opn;
    } t_beat;

    typedef struct {
        logic signed [DELTA_W-1:0] delta;
        logic                      inf;
    } t_answer;

    localparam int STALL_LIMIT = 200000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [1:0]                i_operation;
    logic [3:0]                i_facility;
    logic [3:0]                i_client;
    logic [15:0]               i_amount;
    logic                      i_open_flag;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [DELTA_W-1:0] o_delta_cost;
    logic                      o_infeasible;

    drop_move_greedy_reassign_cost dut (.*);

    // stimulus side: pending beats plus a shadow of what has been loaded
    t_beat     beat_q[$];
    t_answer   answer_q[$];
    bit        cost_written[256];
    int        gen_flow[16];
    int        gen_spare[16];
    bit        gen_open[16];
    int        total_beats;
    int        sent_beats;
    int        errors;
    int        idle_cycles;
    bit        in_taken;

    // predictor state, updated on accepted beats
    bit        pm_open[16];
    int        pm_spare[16];
    int        pm_flow[16];
    int        pm_cost[256];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rand_amt();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 65535);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    task automatic add_beat(input logic [1:0] op, input int fac, input int cli,
                            input int amt, input bit opn);
        t_beat b;
        b.op = op; b.fac = fac[3:0]; b.cli = cli[3:0]; b.amt = amt[15:0]; b.opn = opn;
        beat_q = {beat_q, b};
        case (op)
            OP_LOAD_FAC: begin
                gen_open[fac] = opn;
                gen_spare[fac] = amt;
            end
            OP_LOAD_COST: cost_written[fac * 16 + cli] = 1'b1;
            OP_LOAD_FLOW: gen_flow[cli] = amt;
            default: ;
        endcase
    endtask

    // writes any cost the compute would read, then issues the compute
    task automatic add_compute(input int drop);
        bit rx[16];
        bit any_rx;
        bit any_cli;
        any_rx = 0;
        any_cli = 0;
        for (int f = 0; f < 16; f++) begin
            rx[f] = (f == drop) || (gen_open[f] && gen_spare[f] > 0);
            if (f != drop && gen_open[f] && gen_spare[f] > 0) any_rx = 1;
        end
        for (int c = 0; c < 16; c++)
            if (gen_flow[c] > 0) any_cli = 1;
        if (any_rx && any_cli)
            for (int f = 0; f < 16; f++)
                for (int c = 0; c < 16; c++)
                    if (rx[f] && gen_flow[c] > 0 && !cost_written[f * 16 + c])
                        add_beat(OP_LOAD_COST, f, c, rand_amt(), 0);
        add_beat(OP_COMPUTE, drop, $urandom_range(0, 15), $urandom_range(0, 65535),
                 $urandom_range(0, 1));
    endtask

    function automatic t_answer drop_delta(input int drop);
        t_answer r;
        int      slack[16];
        int      demand[16];
        int      arc_rc[256];
        int      arc_f[256];
        int      arc_c[256];
        int      n;
        int      j;
        int      rc;
        int      m;
        int      fcount;
        int      ccount;
        longint  sum;
        bit      left;
        r.delta = '0;
        r.inf = 1'b0;
        n = 0;
        fcount = 0;
        ccount = 0;
        sum = 0;
        left = 0;
        for (int f = 0; f < 16; f++) begin
            slack[f] = 0;
            if (f != drop && pm_open[f] && pm_spare[f] > 0) begin
                slack[f] = pm_spare[f];
                fcount++;
            end
        end
        for (int c = 0; c < 16; c++) begin
            demand[c] = pm_flow[c];
            if (pm_flow[c] > 0) ccount++;
        end
        if (fcount == 0 || ccount == 0) return r;
        // arcs kept sorted by (reduced cost, facility, client)
        for (int f = 0; f < 16; f++) begin
            if (slack[f] == 0) continue;
            for (int c = 0; c < 16; c++) begin
                if (pm_flow[c] == 0) continue;
                rc = pm_cost[f * 16 + c] - pm_cost[drop * 16 + c];
                j = n;
                while (j > 0 && (rc < arc_rc[j-1] || (rc == arc_rc[j-1] &&
                       (f < arc_f[j-1] || (f == arc_f[j-1] && c < arc_c[j-1]))))) begin
                    arc_rc[j] = arc_rc[j-1];
                    arc_f[j] = arc_f[j-1];
                    arc_c[j] = arc_c[j-1];
                    j--;
                end
                arc_rc[j] = rc;
                arc_f[j] = f;
                arc_c[j] = c;
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (slack[arc_f[i]] == 0 || demand[arc_c[i]] == 0) continue;
            m = (slack[arc_f[i]] < demand[arc_c[i]]) ? slack[arc_f[i]] : demand[arc_c[i]];
            sum += longint'(arc_rc[i]) * longint'(m);
            slack[arc_f[i]] -= m;
            demand[arc_c[i]] -= m;
        end
        for (int c = 0; c < 16; c++)
            if (demand[c] > 0) left = 1;
        if (left) begin
            r.delta = SUM_DMAX[DELTA_W-1:0];
            r.inf = 1'b1;
            return r;
        end
        if (sum > SUM_DMAX) sum = SUM_DMAX;
        if (sum < SUM_DMIN) sum = SUM_DMIN;
        r.delta = sum[DELTA_W-1:0];
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        bit idle_in;
        bit stall_out;
        int phase;
        phase = (total_beats == 0) ? 0 : (sent_beats * 4) / total_beats;
        case (phase)
            1: begin idle_in = ($urandom_range(0, 99) < 76); stall_out = 0; end
            2: begin idle_in = 0; stall_out = ($urandom_range(0, 99) < 76); end
            3: begin
                idle_in = ($urandom_range(0, 99) < 33);
                stall_out = ($urandom_range(0, 99) < 33);
            end
            default: begin idle_in = 0; stall_out = 0; end
        endcase
        i_out_ready <= i_rst_n && !stall_out;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 0;
            if (beat_q.size() > 0 && !idle_in) begin
                t_beat b;
                b = beat_q.pop_front();
                sent_beats++;
                i_in_valid  <= 1'b1;
                i_operation <= b.op;
                i_facility  <= b.fac;
                i_client    <= b.cli;
                i_amount    <= b.amt;
                i_open_flag <= b.opn;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        bit moved;
        moved = 0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            moved = 1;
            in_taken = 1;
            case (i_operation)
                OP_LOAD_FAC: begin
                    pm_open[i_facility] = i_open_flag;
                    pm_spare[i_facility] = i_amount;
                end
                OP_LOAD_COST: pm_cost[{i_facility, i_client}] = i_amount;
                OP_LOAD_FLOW: pm_flow[i_client] = i_amount;
                OP_COMPUTE: answer_q = {answer_q, drop_delta(i_facility)};
                default: ;
            endcase
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            moved = 1;
            if (answer_q.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                t_answer e;
                e = answer_q.pop_front();
                if (o_delta_cost !== e.delta) begin
                    $error("delta_cost: expected %0d, got %0d", e.delta, o_delta_cost);
                    errors++;
                end
                if (o_infeasible !== e.inf) begin
                    $error("infeasible: expected %0d, got %0d", e.inf, o_infeasible);
                    errors++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int drop;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_operation = OP_LOAD_FAC;
        i_facility = '0;
        i_client = '0;
        i_amount = '0;
        i_open_flag = 1'b0;
        errors = 0;
        idle_cycles = 0;
        sent_beats = 0;
        in_taken = 0;
        for (int i = 0; i < 16; i++) begin
            gen_open[i] = 0; gen_spare[i] = 0; gen_flow[i] = 0;
            pm_open[i] = 0; pm_spare[i] = 0; pm_flow[i] = 0;
        end
        for (int i = 0; i < 256; i++) begin
            cost_written[i] = 0;
            pm_cost[i] = 0;
        end

        // directed: empty sets, extremes, closed facility, leftover demand
        add_compute(0);
        add_beat(OP_LOAD_FAC, 15, 0, 65535, 1);
        add_compute(3);
        add_beat(OP_LOAD_FLOW, 0, 15, 65535, 0);
        add_beat(OP_LOAD_FLOW, 0, 0, 1, 0);
        add_beat(OP_LOAD_COST, 0, 0, 65535, 0);
        add_beat(OP_LOAD_COST, 0, 15, 0, 0);
        add_beat(OP_LOAD_COST, 15, 0, 0, 0);
        add_beat(OP_LOAD_COST, 15, 15, 65535, 0);
        add_compute(0);
        add_compute(15);
        add_beat(OP_LOAD_FAC, 0, 0, 0, 1);
        add_beat(OP_LOAD_FAC, 7, 0, 65535, 0);
        add_beat(OP_LOAD_FAC, 15, 0, 3, 1);
        add_compute(0);
        add_beat(OP_LOAD_FAC, 5, 0, 65535, 1);
        add_beat(OP_LOAD_FLOW, 0, 15, 10, 0);
        add_compute(0);
        add_compute(5);

        // random: well-formed load sequences ending in a compute, plus stray loads
        while (beat_q.size() < 1000) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_beat(OP_LOAD_FAC, $urandom_range(0, 15), $urandom_range(0, 15),
                                  rand_amt(), $urandom_range(0, 3) != 0);
                3, 4: add_beat(OP_LOAD_FLOW, $urandom_range(0, 15), $urandom_range(0, 15),
                               ($urandom_range(0, 2) == 0) ? 0 : rand_amt(),
                               $urandom_range(0, 1));
                5, 6: add_beat(OP_LOAD_COST, $urandom_range(0, 15), $urandom_range(0, 15),
                               rand_amt(), $urandom_range(0, 1));
                default: begin
                    drop = $urandom_range(0, 15);
                    if ($urandom_range(0, 1) == 0)
                        for (int f = 0; f < 16; f++)
                            if (gen_open[f] && $urandom_range(0, 2) == 0) drop = f;
                    add_compute(drop);
                end
            endcase
        end
        add_compute($urandom_range(0, 15));
        total_beats = beat_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (beat_q.size() == 0);
        @(posedge i_clk);
        wait (!i_in_valid || in_taken);
        wait (answer_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[drop_move_greedy_reassign_cost.f]
sv/dmgrc_pkg.sv
sv/dmgrc_ram.sv
sv/drop_move_greedy_reassign_cost.sv
tb/tb.sv
